>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds operation and status codes, sizes and the cell command struct.
// No dependencies.
package deq_pkg;

    // Queue geometry
    localparam int DEPTH     = 1024;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;

    // Stream packing
    localparam int IN_BITS   = OP_W + DATA_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STATUS_W + 2 * DATA_W + 1 + COUNT_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_NONE       = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } deq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } deq_status_t;

    // Broadcast command to every cell of the chain
    typedef struct packed {
        logic              f_shr;   // front-ordered row moves toward the tail end
        logic              f_shl;   // front-ordered row moves toward cell 0
        logic              f_wr;    // front-ordered row writes at cell == count
        logic              b_shr;   // back-ordered row moves toward the tail end
        logic              b_shl;   // back-ordered row moves toward cell 0
        logic              b_wr;    // back-ordered row writes at cell == count
        logic [CNT_W-1:0]  count;   // element count before the request
        logic [DATA_W-1:0] value;   // word being pushed
    } cell_cmd_t;

    // Controller status toward the top level
    typedef struct packed {
        logic              out_valid;
        deq_status_t       status;
        logic [CNT_W-1:0]  count;
    } deq_stat_t;

endpackage

>>> rtl/double_ended_queue_top.sv
// Double-ended queue of signed 32-bit words: top level.
// Instantiates deq_ctrl and a chain of deq_cell; depends on deq_pkg.
//
// Usage:
//   Slave stream s_*: one request per item, tdata = op, push_value.
//   Master stream m_*: one result per request, tdata = status, front_value,
//   back_value, is_empty, count.
//   The words sit in a row of DEPTH cells held twice: once in front order
//   and once in back order, so both ends are always at cell 0 and every
//   push or pop only moves words to the neighboring cell.
//   The result is registered: it is valid in the cycle after the request is accepted.
//   Throughput: one request per cycle; the output register frees and
//   refills in the same cycle when m_tready is high.
//   While m_tready is low the result is held and s_tready drops until it
//   is taken; the queue contents stay put meanwhile.
//   Reset empties the queue (count zero) and drops m_tvalid; the cells
//   need no clearing since a word is only shown after it was pushed.
//   Status: done, push rejected when full, pop ignored when empty; front
//   and back read as all ones when the queue is empty.
module double_ended_queue_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [deq_pkg::IN_W-1:0]  s_tdata,   // op[2:0], push_value[34:3]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [deq_pkg::OUT_W-1:0] m_tdata    // status[1:0], front_value[33:2],
                                                 // back_value[65:34], is_empty[66],
                                                 // count[77:67]
);
    import deq_pkg::*;

    cell_cmd_t         cmd;
    deq_stat_t         stat;
    logic [DATA_W-1:0] f_q [DEPTH];
    logic [DATA_W-1:0] b_q [DEPTH];
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;
    logic              is_empty;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] push_value;

    // Unpack the request
    assign op         = s_tdata[OP_W-1:0];
    assign push_value = s_tdata[OP_W +: DATA_W];

    deq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .op         (op),
        .push_value (push_value),
        .out_ready  (m_tready),
        .in_ready   (s_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Cell chain; cell 0 takes the pushed word on a move toward the tail
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] f_lft, f_rgt, b_lft, b_rgt;

        if (i == 0)
        begin : g_head
            assign f_lft = cmd.value;
            assign b_lft = cmd.value;
        end
        else
        begin : g_mid
            assign f_lft = f_q[i-1];
            assign b_lft = b_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign f_rgt = '0;
            assign b_rgt = '0;
        end
        else
        begin : g_link
            assign f_rgt = f_q[i+1];
            assign b_rgt = b_q[i+1];
        end

        deq_cell u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .idx   (IDX_W'(i)),
            .f_lft (f_lft),
            .f_rgt (f_rgt),
            .b_lft (b_lft),
            .b_rgt (b_rgt),
            .f_q   (f_q[i]),
            .b_q   (b_q[i])
        );
    end

    // Result: ends of the queue as left by the last request
    assign is_empty    = (stat.count == '0);
    assign front_value = is_empty ? '1 : f_q[0];
    assign back_value  = is_empty ? '1 : b_q[0];

    assign m_tvalid = stat.out_valid;
    assign m_tdata  = OUT_W'({COUNT_W'(stat.count), is_empty, back_value,
                              front_value, stat.status});

    // Count never goes past the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    // A push to the front that fits shows up as the new front word
    a_push_front: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && op == OP_PUSH_FRONT &&
         stat.count != CNT_W'(DEPTH))
        |=> (f_q[0] == $past(push_value)))
        else $error("pushed front word not at cell 0");

    // A push to the back that fits shows up as the new back word
    a_push_back: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && op == OP_PUSH_BACK &&
         stat.count != CNT_W'(DEPTH))
        |=> (b_q[0] == $past(push_value)))
        else $error("pushed back word not at cell 0");

    // A pop on an empty queue reports it and leaves the count at zero
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && stat.count == '0 &&
         (op == OP_POP_FRONT || op == OP_POP_BACK))
        |=> (stat.status == ST_EMPTY && stat.count == '0))
        else $error("pop on empty not flagged");

    // A held result blocks new requests
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request taken while result stalled");

endmodule

>>> rtl/deq_cell.sv
// One storage cell of the queue chain: a word in front order and a word in
// back order, each loaded from a neighbor or from the pushed word.
// Depends on deq_pkg.
module deq_cell (
    input  logic                       clk,
    input  deq_pkg::cell_cmd_t         cmd,
    input  logic [deq_pkg::IDX_W-1:0]  idx,
    input  logic [deq_pkg::DATA_W-1:0] f_lft,
    input  logic [deq_pkg::DATA_W-1:0] f_rgt,
    input  logic [deq_pkg::DATA_W-1:0] b_lft,
    input  logic [deq_pkg::DATA_W-1:0] b_rgt,
    output logic [deq_pkg::DATA_W-1:0] f_q,
    output logic [deq_pkg::DATA_W-1:0] b_q
);
    import deq_pkg::*;

    logic [DATA_W-1:0] f_reg, f_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic              at_count;

    // This cell sits just past the last element
    assign at_count = (CNT_W'(idx) == cmd.count);

    // Front-ordered word
    always_comb
    begin
        f_next = f_reg;
        if (cmd.f_shr)
        begin
            f_next = f_lft;
        end
        else if (cmd.f_shl)
        begin
            f_next = f_rgt;
        end
        else if (cmd.f_wr && at_count)
        begin
            f_next = cmd.value;
        end
    end

    // Back-ordered word
    always_comb
    begin
        b_next = b_reg;
        if (cmd.b_shr)
        begin
            b_next = b_lft;
        end
        else if (cmd.b_shl)
        begin
            b_next = b_rgt;
        end
        else if (cmd.b_wr && at_count)
        begin
            b_next = cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        b_reg <= b_next;
    end

    assign f_q = f_reg;
    assign b_q = b_reg;

endmodule

>>> rtl/deq_ctrl.sv
// Request decode, element count, status and output register for the queue.
// Drives the command broadcast to the cell chain.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [deq_pkg::OP_W-1:0]   op,
    input  logic [deq_pkg::DATA_W-1:0] push_value,
    input  logic                       out_ready,
    output logic                       in_ready,
    output deq_pkg::cell_cmd_t         cmd,
    output deq_pkg::deq_stat_t         stat
);
    import deq_pkg::*;

    logic              out_valid_reg, out_valid_next;
    deq_status_t       status_reg, status_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              accept;
    logic              is_full;
    logic              is_void;

    // A new request enters once the pending result is gone or leaving
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_void  = (count_reg == '0);

    // Decode the request into cell moves, the new count and status
    always_comb
    begin
        cmd            = '0;
        cmd.count      = count_reg;
        cmd.value      = push_value;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_DONE;
            unique case (op) inside
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (op == OP_PUSH_FRONT)
                        begin
                            cmd.f_shr = 1'b1;
                            cmd.b_wr  = 1'b1;
                        end
                        else
                        begin
                            cmd.b_shr = 1'b1;
                            cmd.f_wr  = 1'b1;
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (is_void)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (op == OP_POP_FRONT)
                        begin
                            cmd.f_shl = 1'b1;
                        end
                        else
                        begin
                            cmd.b_shl = 1'b1;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_DONE;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            count_reg     <= count_next;
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign stat.status    = status_reg;
    assign stat.count     = count_reg;

endmodule

>>> bench/tb.sv
// Testbench for double_ended_queue_top: stream requests in, one result out per request.
// Predicts every result with a shadow deque and checks it field by field.
// Depends on deq_pkg and the RTL of double_ended_queue_top.
`timescale 1ns / 100ps

module tb;
    import deq_pkg::*;

    // Codes outside the operation enum; the block treats them as no operation
    localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam logic [DATA_W-1:0] WORD_NONE = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;

    // Result field positions in m_tdata
    localparam int FRONT_LSB = STATUS_W;
    localparam int BACK_LSB  = FRONT_LSB + DATA_W;
    localparam int EMPTY_BIT = BACK_LSB + DATA_W;
    localparam int COUNT_LSB = EMPTY_BIT + 1;

    localparam int N_DIRECTED = 23;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   front;
        logic [DATA_W-1:0]   back;
        logic                empty;
        logic [COUNT_W-1:0]  count;
    } deq_result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic              fixed_exp;
        deq_result_t       res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    // Shadow deque state
    logic [DATA_W-1:0] shadow_words [DEPTH];
    int                shadow_head;
    int                shadow_tail;
    int                shadow_count;

    deq_result_t       pending_results [$];
    int                mismatch_count;
    int                result_index;
    int                burst_left;

    // Directed requests; results typed in where they are obvious
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{OP_NONE,       32'd0,         1'b1, '{ST_DONE,  WORD_NONE, WORD_NONE, 1'b1, 11'd0}},
        '{OP_POP_FRONT,  32'd0,         1'b1, '{ST_EMPTY, WORD_NONE, WORD_NONE, 1'b1, 11'd0}},
        '{OP_POP_BACK,   WORD_NONE,     1'b1, '{ST_EMPTY, WORD_NONE, WORD_NONE, 1'b1, 11'd0}},
        '{OP_UNUSED_5,   WORD_NONE,     1'b1, '{ST_DONE,  WORD_NONE, WORD_NONE, 1'b1, 11'd0}},
        '{OP_UNUSED_6,   32'd0,         1'b1, '{ST_DONE,  WORD_NONE, WORD_NONE, 1'b1, 11'd0}},
        '{OP_UNUSED_7,   32'hA5A5_A5A5, 1'b1, '{ST_DONE,  WORD_NONE, WORD_NONE, 1'b1, 11'd0}},
        '{OP_PUSH_BACK,  WORD_MAX,      1'b1, '{ST_DONE,  WORD_MAX,  WORD_MAX,  1'b0, 11'd1}},
        '{OP_PUSH_FRONT, WORD_MIN,      1'b1, '{ST_DONE,  WORD_MIN,  WORD_MAX,  1'b0, 11'd2}},
        '{OP_PUSH_BACK,  WORD_NONE,     1'b1, '{ST_DONE,  WORD_MIN,  WORD_NONE, 1'b0, 11'd3}},
        '{OP_PUSH_FRONT, 32'd0,         1'b1, '{ST_DONE,  32'd0,     WORD_NONE, 1'b0, 11'd4}},
        '{OP_NONE,       32'h1234_5678, 1'b1, '{ST_DONE,  32'd0,     WORD_NONE, 1'b0, 11'd4}},
        '{OP_POP_FRONT,  32'd0,         1'b1, '{ST_DONE,  WORD_MIN,  WORD_NONE, 1'b0, 11'd3}},
        '{OP_POP_BACK,   32'd0,         1'b1, '{ST_DONE,  WORD_MIN,  WORD_MAX,  1'b0, 11'd2}},
        '{OP_POP_BACK,   32'd0,         1'b1, '{ST_DONE,  WORD_MIN,  WORD_MIN,  1'b0, 11'd1}},
        '{OP_POP_FRONT,  32'd0,         1'b1, '{ST_DONE,  WORD_NONE, WORD_NONE, 1'b1, 11'd0}},
        '{OP_POP_FRONT,  32'd0,         1'b1, '{ST_EMPTY, WORD_NONE, WORD_NONE, 1'b1, 11'd0}},
        '{OP_PUSH_FRONT, 32'd1,         1'b0, '0},
        '{OP_PUSH_FRONT, 32'h5555_AAAA, 1'b0, '0},
        '{OP_PUSH_BACK,  32'd2,         1'b0, '0},
        '{OP_UNUSED_5,   32'h7FFF_0000, 1'b0, '0},
        '{OP_POP_BACK,   32'd0,         1'b0, '0},
        '{OP_POP_FRONT,  32'd0,         1'b0, '0},
        '{OP_POP_BACK,   32'd0,         1'b0, '0}
    };

    double_ended_queue_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Applies one request to the shadow deque and returns the result it gives
    function automatic deq_result_t deque_step(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
        deq_result_t res;
        res = '0;
        res.status = ST_DONE;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            if (shadow_count >= DEPTH)
            begin
                res.status = ST_FULL;
            end
            else if (op == OP_PUSH_FRONT)
            begin
                shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
                shadow_words[shadow_head] = value;
                shadow_count++;
            end
            else
            begin
                shadow_words[shadow_tail] = value;
                shadow_tail = (shadow_tail == DEPTH - 1) ? 0 : shadow_tail + 1;
                shadow_count++;
            end
        end
        else if (op == OP_POP_FRONT || op == OP_POP_BACK)
        begin
            if (shadow_count == 0)
            begin
                res.status = ST_EMPTY;
            end
            else if (op == OP_POP_FRONT)
            begin
                shadow_head = (shadow_head == DEPTH - 1) ? 0 : shadow_head + 1;
                shadow_count--;
            end
            else
            begin
                shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
                shadow_count--;
            end
        end
        if (shadow_count != 0)
        begin
            res.front = shadow_words[shadow_head];
            res.back  = shadow_words[(shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1];
        end
        else
        begin
            res.front = WORD_NONE;
            res.back  = WORD_NONE;
        end
        res.empty = (shadow_count == 0);
        res.count = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    // Random op; push_pct weights pushes against pops, a few noise codes mixed in
    function automatic logic [OP_W-1:0] pick_op(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return OP_NONE;
        if (r < 8)
            return 3'($urandom_range(5, 7));
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return WORD_NONE;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Drives one request in bursts with random gaps; records its result on acceptance
    task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                             logic fixed_exp, deq_result_t fixed_res);
        int          gap;
        deq_result_t res;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({value, op});
        do @(posedge clk); while (!s_tready);
        res = deque_step(op, value);
        pending_results.insert(pending_results.size(), fixed_exp ? fixed_res : res);
    endtask

    // Holds the sender off until every outstanding result has come back
    task automatic wait_results_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("result %0d: %s got %h, want %h", result_index, field, got, want);
        mismatch_count++;
    endtask

    // Receiver: ready runs of random length, short stalls, now and then a long clean run
    initial
    begin
        int run;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("result %0d: arrived with no request outstanding", result_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_tdata[STATUS_W-1:0] != want.status)
                    report_mismatch("status", 32'(m_tdata[STATUS_W-1:0]), 32'(want.status));
                if (m_tdata[FRONT_LSB +: DATA_W] != want.front)
                    report_mismatch("front_value", m_tdata[FRONT_LSB +: DATA_W], want.front);
                if (m_tdata[BACK_LSB +: DATA_W] != want.back)
                    report_mismatch("back_value", m_tdata[BACK_LSB +: DATA_W], want.back);
                if (m_tdata[EMPTY_BIT] != want.empty)
                    report_mismatch("is_empty", 32'(m_tdata[EMPTY_BIT]), 32'(want.empty));
                if (m_tdata[COUNT_LSB +: COUNT_W] != want.count)
                    report_mismatch("count", 32'(m_tdata[COUNT_LSB +: COUNT_W]), 32'(want.count));
            end
            result_index++;
        end
    end

    // Stimulus
    initial
    begin
        int seg_len;
        int push_pct;
        int sent;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        shadow_head    = 0;
        shadow_tail    = 0;
        shadow_count   = 0;
        mismatch_count = 0;
        result_index   = 0;
        burst_left     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].fixed_exp, directed_rows[i].res);
        wait_results_drained();

        // Fill to full from both ends, wrapping the indices, push against full, then mix pushes and pops
        while (shadow_count < DEPTH)
            send_item(pick_op(92), pick_value(), 1'b0, '0);
        repeat (6)
            send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                      pick_value(), 1'b0, '0);
        repeat (40)
            send_item(pick_op(50), pick_value(), 1'b0, '0);
        wait_results_drained();

        // Drain to empty and pop past it
        while (shadow_count > 0)
            send_item(pick_op(8), pick_value(), 1'b0, '0);
        repeat (3)
            send_item($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                      pick_value(), 1'b0, '0);

        // Random segments, each leaning toward pushes, pops or neither
        sent = 0;
        while (sent < 750)
        begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       push_pct = 25;
                1:       push_pct = 50;
                default: push_pct = 75;
            endcase
            repeat (seg_len)
                send_item(pick_op(push_pct), pick_value(), 1'b0, '0);
            sent += seg_len;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
